FILE: rtl/spq_pkg.sv
// Shared types, codes and defaults for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned OccWidth = 5;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_REMOVE  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  typedef enum logic [1:0] {
    WR_NEW_AT_IDX,
    WR_RD_AT_IDX,
    WR_RD_BELOW_IDX
  } wr_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_SCAN_CHK,
    S_SCAN_CMP,
    S_SHF_CHK,
    S_SHF_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    load;
    idx_op_e idx_op;
    logic    rd_en;
    logic    rd_prev;
    logic    wr_en;
    wr_sel_e wr_sel;
    cnt_op_e cnt_op;
    logic    res_set;
    status_e res_status;
    logic    res_cap;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic idx_zero;
    logic idx_at_count;
    logic new_lt_rd;
    logic new_eq_rd;
    logic is_extract;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/spq_dp.sv
// Datapath of the sorted priority queue: entry memory, count, index and result registers.
`default_nettype none

module spq_dp #(
  parameter int unsigned CAPACITY = spq_pkg::DefaultCapacity
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [1:0]                           req_type_i,
  input  wire logic signed [spq_pkg::ValueWidth-1:0] item_value_i,
  input  wire logic                                 out_stall_i,
  input  wire spq_pkg::cmd_t                        cmd_i,
  output spq_pkg::sts_t                             sts_o,
  output logic                                      out_valid_o,
  output logic signed [spq_pkg::ValueWidth-1:0]     out_value_o,
  output logic [1:0]                                status_o,
  output logic [spq_pkg::OccWidth-1:0]              occupancy_o
);

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic signed [spq_pkg::ValueWidth-1:0] mem [CAPACITY];
  logic signed [spq_pkg::ValueWidth-1:0] rd_data_q;
  logic signed [spq_pkg::ValueWidth-1:0] new_value_q;
  logic signed [spq_pkg::ValueWidth-1:0] res_value_q;
  logic signed [spq_pkg::ValueWidth-1:0] out_value_q;
  logic signed [spq_pkg::ValueWidth-1:0] wr_data;
  spq_pkg::status_e                      res_status_q;
  logic [1:0]                            out_status_q;
  logic [spq_pkg::OccWidth-1:0]          out_occ_q;
  logic                                  is_extract_q;
  logic                                  out_valid_q, out_valid_d;
  logic [CntW-1:0]                       count_q, count_d;
  logic [CntW-1:0]                       idx_q, idx_d;
  logic [AddrW-1:0]                      idx_addr, idx_m1_addr, rd_addr, wr_addr;
  logic [31:0]                           count_wide;

  assign idx_addr    = idx_q[AddrW-1:0];
  assign idx_m1_addr = AddrW'(idx_q - CntW'(1));
  assign rd_addr     = cmd_i.rd_prev ? idx_m1_addr : idx_addr;
  assign count_wide  = 32'(count_q);

  always_comb begin
    case (cmd_i.wr_sel)
      spq_pkg::WR_NEW_AT_IDX: begin
        wr_addr = idx_addr;
        wr_data = new_value_q;
      end
      spq_pkg::WR_RD_AT_IDX: begin
        wr_addr = idx_addr;
        wr_data = rd_data_q;
      end
      spq_pkg::WR_RD_BELOW_IDX: begin
        wr_addr = idx_m1_addr;
        wr_data = rd_data_q;
      end
      default: begin
        wr_addr = idx_addr;
        wr_data = new_value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.idx_op)
      spq_pkg::IDX_ZERO:  idx_d = '0;
      spq_pkg::IDX_COUNT: idx_d = count_q;
      spq_pkg::IDX_INC:   idx_d = idx_q + CntW'(1);
      spq_pkg::IDX_DEC:   idx_d = idx_q - CntW'(1);
      default:            idx_d = idx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      spq_pkg::CNT_INC: count_d = count_q + CntW'(1);
      spq_pkg::CNT_DEC: count_d = count_q - CntW'(1);
      default:          count_d = count_q;
    endcase
  end

  assign out_valid_d = cmd_i.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_value_q  <= item_value_i;
      is_extract_q <= (req_type_i == spq_pkg::REQ_EXTRACT);
      res_value_q  <= '0;
    end else if (cmd_i.res_cap) begin
      res_value_q <= rd_data_q;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_occ_q    <= count_wide[spq_pkg::OccWidth-1:0];
    end
  end

  assign sts_o.full         = (count_q == CntW'(CAPACITY));
  assign sts_o.idx_zero     = (idx_q == '0);
  assign sts_o.idx_at_count = (idx_q == count_q);
  assign sts_o.new_lt_rd    = (new_value_q < rd_data_q);
  assign sts_o.new_eq_rd    = (new_value_q == rd_data_q);
  assign sts_o.is_extract   = is_extract_q;
  assign sts_o.out_busy     = out_valid_q & out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = out_status_q;
  assign occupancy_o = out_occ_q;

endmodule

`default_nettype wire

FILE: rtl/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
`default_nettype none

module spq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    req_type_i,
  input  wire spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t      cmd_o,
  output logic               in_stall_o
);

  spq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.idx_op     = spq_pkg::IDX_HOLD;
    cmd_o.cnt_op     = spq_pkg::CNT_HOLD;
    cmd_o.wr_sel     = spq_pkg::WR_NEW_AT_IDX;
    cmd_o.res_status = spq_pkg::ST_OK;
    in_stall_o       = (state_q != spq_pkg::S_IDLE);

    case (state_q)
      spq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (req_type_i)
            spq_pkg::REQ_INSERT: begin
              if (sts_i.full) begin
                cmd_o.res_set    = 1'b1;
                cmd_o.res_status = spq_pkg::ST_FULL;
                state_d          = spq_pkg::S_DONE;
              end else begin
                cmd_o.idx_op = spq_pkg::IDX_COUNT;
                state_d      = spq_pkg::S_INS_CHK;
              end
            end
            spq_pkg::REQ_EXTRACT, spq_pkg::REQ_REMOVE: begin
              cmd_o.idx_op = spq_pkg::IDX_ZERO;
              state_d      = spq_pkg::S_SCAN_CHK;
            end
            default: begin
              cmd_o.res_set = 1'b1;
              state_d       = spq_pkg::S_DONE;
            end
          endcase
        end
      end
      spq_pkg::S_INS_CHK: begin
        if (sts_i.idx_zero) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.cnt_op  = spq_pkg::CNT_INC;
          cmd_o.res_set = 1'b1;
          state_d       = spq_pkg::S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
          state_d       = spq_pkg::S_INS_CMP;
        end
      end
      spq_pkg::S_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.new_lt_rd) begin
          cmd_o.wr_sel = spq_pkg::WR_RD_AT_IDX;
          cmd_o.idx_op = spq_pkg::IDX_DEC;
          state_d      = spq_pkg::S_INS_CHK;
        end else begin
          cmd_o.cnt_op  = spq_pkg::CNT_INC;
          cmd_o.res_set = 1'b1;
          state_d       = spq_pkg::S_DONE;
        end
      end
      spq_pkg::S_SCAN_CHK: begin
        if (sts_i.idx_at_count) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = sts_i.is_extract ? spq_pkg::ST_EMPTY : spq_pkg::ST_NOTFOUND;
          state_d          = spq_pkg::S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = spq_pkg::S_SCAN_CMP;
        end
      end
      spq_pkg::S_SCAN_CMP: begin
        cmd_o.idx_op = spq_pkg::IDX_INC;
        if (sts_i.is_extract || sts_i.new_eq_rd) begin
          cmd_o.res_cap = sts_i.is_extract;
          cmd_o.res_set = 1'b1;
          state_d       = spq_pkg::S_SHF_CHK;
        end else begin
          state_d = spq_pkg::S_SCAN_CHK;
        end
      end
      spq_pkg::S_SHF_CHK: begin
        if (sts_i.idx_at_count) begin
          cmd_o.cnt_op = spq_pkg::CNT_DEC;
          state_d      = spq_pkg::S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = spq_pkg::S_SHF_WR;
        end
      end
      spq_pkg::S_SHF_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = spq_pkg::WR_RD_BELOW_IDX;
        cmd_o.idx_op = spq_pkg::IDX_INC;
        state_d      = spq_pkg::S_SHF_CHK;
      end
      spq_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller and datapath.
//
// The queue holds up to CAPACITY signed 32-bit values in ascending order in a
// single-port-read, single-port-write memory. Each input item carries a request
// (insert, extract minimum, remove value) and yields exactly one result item
// with the extracted value, a status and the occupancy after the request.
// Both channels use valid and stall; an item moves on a clock edge with valid
// high and stall low. Input stall is high while a request is being worked on.
// With the memory's single read port, every step first reads an entry and then
// compares or moves it. An insert moves each larger entry up one place from the
// back; an extract or a remove scans from the front and shifts the entries behind
// the match down. A full insert or an unused code goes straight to its result.
// The controller returns to idle as the result enters the output register and
// accepts the next item from then on. A finished result sits in the output
// register; while the receiver stalls it holds steady, the next item is still
// accepted and worked on, and its result waits until the output register is free.
// Reset empties the queue and drops any pending result; the memory contents
// are not cleared, since only held positions are ever read.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = spq_pkg::DefaultCapacity
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic [1:0]                            req_type_i,
  input  wire logic signed [spq_pkg::ValueWidth-1:0] item_value_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [spq_pkg::ValueWidth-1:0]      out_value_o,
  output logic [1:0]                                 status_o,
  output logic [spq_pkg::OccWidth-1:0]               occupancy_o
);

  spq_pkg::cmd_t cmd;
  spq_pkg::sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_value_o  (out_value_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

endmodule

`default_nettype wire

FILE: rtl/spq_checker.sv
// Port-level assertions for the sorted priority queue and their bind.
`default_nettype none

module spq_checker #(
  parameter int unsigned CAPACITY = spq_pkg::DefaultCapacity
) (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  out_valid_o,
  input wire logic                                  out_stall_i,
  input wire logic signed [spq_pkg::ValueWidth-1:0] out_value_o,
  input wire logic [1:0]                            status_o,
  input wire logic [spq_pkg::OccWidth-1:0]          occupancy_o
);

  localparam logic [spq_pkg::OccWidth-1:0] FullOcc = spq_pkg::OccWidth'(CAPACITY);
  localparam bit SmallCap = (CAPACITY < 32);

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && SmallCap |-> occupancy_o <= FullOcc)
    else $error("occupancy above capacity");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::ST_EMPTY |-> occupancy_o == '0)
    else $error("empty status with entries held");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == spq_pkg::ST_FULL |-> occupancy_o == FullOcc)
    else $error("full status below capacity");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != spq_pkg::ST_OK |-> out_value_o == '0)
    else $error("nonzero value on a failed request");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o)
      && $stable(status_o) && $stable(occupancy_o))
    else $error("stalled result item changed");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_value_o (out_value_o),
  .status_o    (status_o),
  .occupancy_o (occupancy_o)
);

`default_nettype wire

FILE: dv/sorted_priority_queue_test.sv
// Testbench for the sorted priority queue: directed table, random phases, in-order result check.
`timescale 1ns / 100ps

module sorted_priority_queue_test;

  localparam int unsigned ValueWidth = spq_pkg::ValueWidth;
  localparam int unsigned OccWidth = spq_pkg::OccWidth;
  localparam int unsigned Capacity = spq_pkg::DefaultCapacity;
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned DrainCycles = 50;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    spq_pkg::status_e             status;
    logic [OccWidth-1:0]          occ;
  } pq_result_t;

  typedef struct {
    logic [1:0]            req;
    logic [ValueWidth-1:0] value;
    int unsigned           reps;
    bit                    known;
    logic [ValueWidth-1:0] exp_value;
    spq_pkg::status_e      exp_status;
    logic [OccWidth-1:0]   exp_occ;
  } plan_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   req_type_i = spq_pkg::REQ_INSERT;
  logic signed [ValueWidth-1:0] item_value_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [ValueWidth-1:0] out_value_o;
  logic [1:0]                   status_o;
  logic [OccWidth-1:0]          occupancy_o;

  logic signed [ValueWidth-1:0] held_values[$];
  pq_result_t                   pending_results[$];
  int unsigned                  error_count = 0;
  int unsigned                  burst_left = 0;

  sorted_priority_queue #(.CAPACITY(Capacity)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic pq_result_t apply_request(logic [1:0] req,
                                               logic signed [ValueWidth-1:0] value);
    pq_result_t r;
    int pos;
    r.value = '0;
    r.status = spq_pkg::ST_OK;
    pos = 0;
    case (req)
      spq_pkg::REQ_INSERT: begin
        if (held_values.size() >= Capacity) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          while (pos < held_values.size() && !(value < held_values[pos])) pos++;
          held_values.insert(pos, value);
        end
      end
      spq_pkg::REQ_EXTRACT: begin
        if (held_values.size() == 0) r.status = spq_pkg::ST_EMPTY;
        else r.value = held_values.pop_front();
      end
      spq_pkg::REQ_REMOVE: begin
        while (pos < held_values.size() && held_values[pos] !== value) pos++;
        if (pos >= held_values.size()) r.status = spq_pkg::ST_NOTFOUND;
        else held_values.delete(pos);
      end
      default: ;
    endcase
    r.occ = OccWidth'(held_values.size());
    return r;
  endfunction

  function automatic logic signed [ValueWidth-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return $signed(ValueWidth'($urandom_range(8))) - 4;
    if (roll < 85) return $urandom;
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h8000_0001;
      4: return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // The sender idles in random gaps between bursts of random length.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(99) < 30) ? 0 : $urandom_range(10, 1);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(30, 1);
    end
    burst_left--;
  endtask

  task automatic offer_request(logic [1:0] req, logic signed [ValueWidth-1:0] value,
                               bit known, pq_result_t typed);
    pq_result_t predicted;
    pace_sender();
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    req_type_i <= req;
    item_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_request(req, value);
    pending_results.push_back(known ? typed : predicted);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    wait (pending_results.size() == 0);
  endtask

  always @(posedge clk_i) begin : check_results
    pq_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: value %0d status %0d occupancy %0d",
               out_value_o, status_o, occupancy_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_value_o !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_value_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          error_count++;
        end
        if (occupancy_o !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy_o);
          error_count++;
        end
      end
    end
  end

  // The receiver stalls on its own pattern and holds off twice for a long stretch.
  initial begin : receiver
    int unsigned cycle_no;
    int unsigned seg_len;
    int unsigned stall_pct;
    cycle_no = 0;
    forever begin
      seg_len = $urandom_range(80, 10);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
      repeat (seg_len) begin
        @(negedge clk_i);
        cycle_no++;
        if (cycle_no == 3000 || cycle_no == 12000) begin
          out_stall_i <= 1'b1;
          repeat (400) @(negedge clk_i);
          cycle_no += 400;
        end
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin : stimulus
    plan_row_t plan[19];
    pq_result_t typed;
    logic [1:0] req;
    logic signed [ValueWidth-1:0] value;
    int unsigned items_sent;
    int unsigned phase_len;
    int unsigned phase_kind;
    int unsigned roll;
    int unsigned ins_pct;
    int unsigned ext_pct;

    plan = '{
      '{spq_pkg::REQ_EXTRACT, 32'h0000_0000, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_EMPTY, 5'd0},
      '{spq_pkg::REQ_REMOVE, 32'h0000_0005, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_NOTFOUND, 5'd0},
      '{spq_pkg::REQ_INSERT, 32'h7fff_ffff, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd1},
      '{spq_pkg::REQ_INSERT, 32'h8000_0000, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd2},
      '{spq_pkg::REQ_INSERT, 32'h0000_0000, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd3},
      '{spq_pkg::REQ_INSERT, 32'hffff_ffff, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd4},
      '{spq_pkg::REQ_INSERT, 32'h0000_0000, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd5},
      '{spq_pkg::REQ_EXTRACT, 32'hffff_ffff, 1, 1'b1, 32'h8000_0000, spq_pkg::ST_OK, 5'd4},
      '{spq_pkg::REQ_EXTRACT, 32'h1234_5678, 1, 1'b1, 32'hffff_ffff, spq_pkg::ST_OK, 5'd3},
      '{spq_pkg::REQ_REMOVE, 32'h0000_0000, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd2},
      '{ReqUnused, 32'h5555_5555, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd2},
      '{spq_pkg::REQ_EXTRACT, 32'h0000_0000, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd1},
      '{spq_pkg::REQ_EXTRACT, 32'h0000_0000, 1, 1'b1, 32'h7fff_ffff, spq_pkg::ST_OK, 5'd0},
      '{spq_pkg::REQ_INSERT, 32'h0000_0100, 16, 1'b0, 32'h0000_0000, spq_pkg::ST_OK, 5'd0},
      '{spq_pkg::REQ_INSERT, 32'haaaa_aaaa, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_FULL, 5'd16},
      '{ReqUnused, 32'h0000_0000, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd16},
      '{spq_pkg::REQ_REMOVE, 32'h0000_0100, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd15},
      '{spq_pkg::REQ_INSERT, 32'h8000_0000, 1, 1'b1, 32'h0000_0000, spq_pkg::ST_OK, 5'd16},
      '{spq_pkg::REQ_EXTRACT, 32'h0000_0000, 1, 1'b1, 32'h8000_0000, spq_pkg::ST_OK, 5'd15}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      typed.value = plan[i].exp_value;
      typed.status = plan[i].exp_status;
      typed.occ = plan[i].exp_occ;
      repeat (plan[i].reps) offer_request(plan[i].req, plan[i].value, plan[i].known, typed);
    end

    // Random phases lean toward filling, draining or a balanced mix.
    typed = '0;
    items_sent = 0;
    while (items_sent < RandomItems) begin
      pause_until_drained();
      phase_len = $urandom_range(80, 30);
      phase_kind = $urandom_range(2);
      case (phase_kind)
        0: begin ins_pct = 65; ext_pct = 15; end
        1: begin ins_pct = 20; ext_pct = 50; end
        default: begin ins_pct = 40; ext_pct = 30; end
      endcase
      repeat (phase_len) begin
        roll = $urandom_range(99);
        value = pick_value();
        if (roll < ins_pct) begin
          req = spq_pkg::REQ_INSERT;
        end else if (roll < ins_pct + ext_pct) begin
          req = spq_pkg::REQ_EXTRACT;
          value = $urandom;
        end else if (roll < 98) begin
          req = spq_pkg::REQ_REMOVE;
          if (held_values.size() != 0 && $urandom_range(99) < 60)
            value = held_values[$urandom_range(held_values.size() - 1)];
        end else begin
          req = ReqUnused;
        end
        offer_request(req, value, 1'b0, typed);
        items_sent++;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sorted_priority_queue.f
rtl/spq_pkg.sv
rtl/spq_dp.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
dv/sorted_priority_queue_test.sv
